### hw/rtl/sadee_pkg.sv
// shared types and constants for the block sad engine with early exit
// no dependencies; imported by every module of the block

package sadee_pkg;

  localparam int LANES    = 4;
  localparam int BYTE_W   = 8;
  localparam int SUM_W    = 24;
  localparam int LIMIT_W  = 24;
  localparam int SAD_W    = 24;
  // four 8-bit absolute differences fit in 10 bits
  localparam int ADD_W    = 10;
  localparam int CMP_W    = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = {LIMIT_W{1'b1}};
  localparam logic [SUM_W-1:0]   SUM_MAX     = {SUM_W{1'b1}};

  typedef logic [LANES-1:0][BYTE_W-1:0] lane_bytes_t;

  // row and block markers of one transaction
  typedef struct packed {
    logic row_last;
    logic block_last;
  } item_ctl_t;

endpackage

### hw/rtl/sadee_diff.sv
// absolute differences of the four lane pairs, summed
// depends on sadee_pkg

module sadee_diff
  import sadee_pkg::*;
(
  input  lane_bytes_t       cur_bytes,
  input  lane_bytes_t       ref_bytes,
  output logic [ADD_W-1:0]  diff_sum
);

  logic [LANES-1:0][BYTE_W-1:0] lane_diff;

  // per-lane absolute difference
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      if (cur_bytes[i] > ref_bytes[i]) begin
        lane_diff[i] = cur_bytes[i] - ref_bytes[i];
      end else begin
        lane_diff[i] = ref_bytes[i] - cur_bytes[i];
      end
    end
  end

  // two-level adder tree
  assign diff_sum = (ADD_W'(lane_diff[0]) + ADD_W'(lane_diff[1]))
                  + (ADD_W'(lane_diff[2]) + ADD_W'(lane_diff[3]));

endmodule

### hw/rtl/sadee_accum.sv
// running sum, early-exit decision and result register
// depends on sadee_pkg

module sadee_accum
  import sadee_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                item_take,
  input  item_ctl_t           item_ctl,
  input  logic [ADD_W-1:0]    diff_sum,
  input  logic [LIMIT_W-1:0]  limit,
  input  logic                res_stall,
  output logic                res_valid,
  output logic [SAD_W-1:0]    res_sad,
  output logic                res_early
);

  logic [SUM_W-1:0] running_sum;
  logic [SUM_W-1:0] running_sum_next;
  logic             skip_rest;
  logic             skip_rest_next;
  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] sum_sat;
  logic             over_limit;
  logic             emit;
  logic             emit_early;

  // saturating add and limit compare
  assign sum_wide   = {1'b0, running_sum} + (SUM_W + 1)'(diff_sum);
  assign sum_sat    = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
  assign over_limit = CMP_W'(sum_sat) > CMP_W'(limit);

  // block state update for one transaction
  always_comb begin
    running_sum_next = running_sum;
    skip_rest_next   = skip_rest;
    emit             = 1'b0;
    emit_early       = 1'b0;
    if (skip_rest) begin
      if (item_ctl.block_last) begin
        skip_rest_next   = 1'b0;
        running_sum_next = '0;
      end
    end else if ((item_ctl.row_last || item_ctl.block_last) && over_limit) begin
      emit             = 1'b1;
      emit_early       = 1'b1;
      running_sum_next = '0;
      skip_rest_next   = !item_ctl.block_last;
    end else if (item_ctl.block_last) begin
      emit             = 1'b1;
      running_sum_next = '0;
    end else begin
      running_sum_next = sum_sat;
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      skip_rest   <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      if (item_take) begin
        running_sum <= running_sum_next;
        skip_rest   <= skip_rest_next;
      end
      if (item_take && emit) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (item_take && emit) begin
      res_sad   <= SAD_W'(sum_sat);
      res_early <= emit_early;
    end
  end

endmodule

### hw/rtl/block_sad_early_exit.sv
// Block sum of absolute differences with early exit at row ends.
// Input channel (in_valid / in_stall): four current and four reference
// bytes plus row_last and block_last per transaction. Output channel
// (out_valid / out_stall): sad_value and stopped_early, zero or one result
// per input transaction. Config channel (cfg_valid / cfg_ready, always
// ready): writes early_exit_limit; write only while the block is idle.
// Pipeline: the input register takes a transaction, and the result register
// loads from it through the combinational differences and accumulate.
// Throughput: one transaction per cycle while no stalled result is pending,
// set by the combinational saturating accumulate between the two registers.
// Reset (rst, synchronous): running sum and skip flag clear, limit returns
// to all ones, both pipeline stages empty.
// When the receiver stalls, the result register holds its payload; while a
// stalled result is pending, a transaction in the input register waits and
// the input channel stalls.
// depends on sadee_pkg, sadee_diff, sadee_accum

module block_sad_early_exit
  import sadee_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [BYTE_W-1:0]   cur_byte_0,
  input  logic [BYTE_W-1:0]   cur_byte_1,
  input  logic [BYTE_W-1:0]   cur_byte_2,
  input  logic [BYTE_W-1:0]   cur_byte_3,
  input  logic [BYTE_W-1:0]   ref_byte_0,
  input  logic [BYTE_W-1:0]   ref_byte_1,
  input  logic [BYTE_W-1:0]   ref_byte_2,
  input  logic [BYTE_W-1:0]   ref_byte_3,
  input  logic                row_last,
  input  logic                block_last,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SAD_W-1:0]    sad_value,
  output logic                stopped_early,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [LIMIT_W-1:0]  cfg_data
);

  logic [LIMIT_W-1:0] early_exit_limit;
  logic               stage_valid;
  lane_bytes_t        stage_cur;
  lane_bytes_t        stage_ref;
  item_ctl_t          stage_ctl;
  logic               item_take;
  logic               in_take;
  logic [ADD_W-1:0]   diff_sum;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      early_exit_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      early_exit_limit <= cfg_data;
    end
  end

  // pipeline handshake
  assign item_take = stage_valid && (!out_valid || !out_stall);
  assign in_stall  = stage_valid && !item_take;
  assign in_take   = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_take) begin
      stage_valid <= 1'b1;
    end else if (item_take) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stage_cur           <= {cur_byte_3, cur_byte_2, cur_byte_1, cur_byte_0};
      stage_ref           <= {ref_byte_3, ref_byte_2, ref_byte_1, ref_byte_0};
      stage_ctl.row_last   <= row_last;
      stage_ctl.block_last <= block_last;
    end
  end

  sadee_diff u_diff (
    .cur_bytes (stage_cur),
    .ref_bytes (stage_ref),
    .diff_sum  (diff_sum)
  );

  sadee_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .item_take (item_take),
    .item_ctl  (stage_ctl),
    .diff_sum  (diff_sum),
    .limit     (early_exit_limit),
    .res_stall (out_stall),
    .res_valid (out_valid),
    .res_sad   (sad_value),
    .res_early (stopped_early)
  );

endmodule

### tb/sv/sad_checker.sv
// result checker for block_sad_early_exit: tracks the running block sum,
// predicts each result and compares it with what the block emits
// depends on sadee_pkg

module sad_checker
  import sadee_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [BYTE_W-1:0]  cur_byte_0,
  input  logic [BYTE_W-1:0]  cur_byte_1,
  input  logic [BYTE_W-1:0]  cur_byte_2,
  input  logic [BYTE_W-1:0]  cur_byte_3,
  input  logic [BYTE_W-1:0]  ref_byte_0,
  input  logic [BYTE_W-1:0]  ref_byte_1,
  input  logic [BYTE_W-1:0]  ref_byte_2,
  input  logic [BYTE_W-1:0]  ref_byte_3,
  input  logic               row_last,
  input  logic               block_last,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [SAD_W-1:0]   sad_value,
  input  logic               stopped_early,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data,
  output int                 fail_count,
  output int                 pending_results,
  output int                 items_seen,
  output int                 results_seen,
  output int                 exits_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [SAD_W-1:0] sad;
    logic             early;
  } sad_result_t;

  sad_result_t        sad_expected_q[$];
  logic [SUM_W-1:0]   block_sum;
  logic               skipping_block;
  logic [LIMIT_W-1:0] exit_limit;

  always @(posedge clk) begin : sad_predict
    sad_result_t      got;
    sad_result_t      want;
    lane_bytes_t      cur_lanes;
    lane_bytes_t      refr_lanes;
    logic [SUM_W:0]   widened;
    int               lane_sum;

    if (rst) begin
      exit_limit = LIMIT_RESET;
      block_sum = '0;
      skipping_block = 1'b0;
      sad_expected_q.delete();
      fail_count = 0;
      items_seen = 0;
      results_seen = 0;
      exits_seen = 0;
    end else begin
      // compare an emitted result with the oldest prediction
      if (out_valid && !out_stall) begin
        got = '{sad: sad_value, early: stopped_early};
        results_seen++;
        if (sad_expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("%0t: result with none expected: sad %0d early %0b",
                     $realtime, got.sad, got.early);
        end else begin
          want = sad_expected_q.pop_front();
          if (got != want) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display("%0t: mismatch: expected sad %0d early %0b, got sad %0d early %0b",
                       $realtime, want.sad, want.early, got.sad, got.early);
          end
        end
      end

      // limit register write
      if (cfg_valid && cfg_ready)
        exit_limit = cfg_data;

      // accumulate an accepted input transaction
      if (in_valid && !in_stall) begin
        items_seen++;
        if (skipping_block) begin
          // rest of an exited block is dropped until its end marker
          if (block_last) begin
            skipping_block = 1'b0;
            block_sum = '0;
          end
        end else begin
          cur_lanes = {cur_byte_3, cur_byte_2, cur_byte_1, cur_byte_0};
          refr_lanes = {ref_byte_3, ref_byte_2, ref_byte_1, ref_byte_0};
          lane_sum = 0;
          for (int lane = 0; lane < LANES; lane++)
            lane_sum += (cur_lanes[lane] > refr_lanes[lane]) ?
                        cur_lanes[lane] - refr_lanes[lane] :
                        refr_lanes[lane] - cur_lanes[lane];
          widened = (SUM_W + 1)'(block_sum) + (SUM_W + 1)'(lane_sum);
          block_sum = widened[SUM_W] ? SUM_MAX : widened[SUM_W-1:0];

          // block end counts as a row end for the limit check
          if ((row_last || block_last) && block_sum > exit_limit) begin
            sad_expected_q.push_back('{sad: block_sum[SAD_W-1:0], early: 1'b1});
            exits_seen++;
            block_sum = '0;
            skipping_block = !block_last;
          end else if (block_last) begin
            sad_expected_q.push_back('{sad: block_sum[SAD_W-1:0], early: 1'b0});
            block_sum = '0;
          end
        end
      end
    end
    pending_results = sad_expected_q.size();
  end

endmodule

### tb/sv/testbench.sv
// top of the block_sad_early_exit testbench: clock, reset, stimulus with
// random idling on both channels, limit writes and the final verdict
// depends on sadee_pkg, block_sad_early_exit and sad_checker

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sadee_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 8;
  localparam int SEGMENT_ITEMS  = 148;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [BYTE_W-1:0]  cur_byte_0 = '0;
  logic [BYTE_W-1:0]  cur_byte_1 = '0;
  logic [BYTE_W-1:0]  cur_byte_2 = '0;
  logic [BYTE_W-1:0]  cur_byte_3 = '0;
  logic [BYTE_W-1:0]  ref_byte_0 = '0;
  logic [BYTE_W-1:0]  ref_byte_1 = '0;
  logic [BYTE_W-1:0]  ref_byte_2 = '0;
  logic [BYTE_W-1:0]  ref_byte_3 = '0;
  logic               row_last = 1'b0;
  logic               block_last = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [SAD_W-1:0]   sad_value;
  logic               stopped_early;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_data = '0;

  int fail_count;
  int pending_results;
  int items_seen;
  int results_seen;
  int exits_seen;

  int send_idle_pct = 16;
  int stall_pct = 86;
  int limit_writes = 0;
  int quiet_cycles = 0;

  block_sad_early_exit u_dut (.*);

  sad_checker u_check (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stall pattern
  always @(posedge clk)
    out_stall <= ($urandom_range(99) < stall_pct);

  // watchdog on cycles without any accepted transaction
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", quiet_cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // one input transaction, with random idle cycles ahead of it
  task automatic send_item(input lane_bytes_t cur, input lane_bytes_t refr,
                           input logic rl, input logic bl);
    logic taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {cur_byte_3, cur_byte_2, cur_byte_1, cur_byte_0} <= cur;
    {ref_byte_3, ref_byte_2, ref_byte_1, ref_byte_0} <= refr;
    row_last <= rl;
    block_last <= bl;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  // stop sending until every predicted result has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results != 0);
    @(posedge clk);
  endtask

  // limit write, only with the pipeline empty
  task automatic write_limit(input logic [LIMIT_W-1:0] limit);
    logic taken;
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= limit;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    limit_writes++;
  endtask

  // lane bytes: random, near-equal, equal or at the byte extremes
  task automatic make_lanes(output lane_bytes_t cur, output lane_bytes_t refr);
    int mode;
    mode = $urandom_range(5);
    for (int lane = 0; lane < LANES; lane++) begin
      cur[lane] = BYTE_W'($urandom_range(255));
      case (mode)
        1, 2: refr[lane] = cur[lane] + BYTE_W'($urandom_range(14)) - 8'd7;
        3: refr[lane] = cur[lane];
        4: begin
          cur[lane] = $urandom_range(1) ? 8'hFF : 8'h00;
          refr[lane] = $urandom_range(1) ? 8'hFF : 8'h00;
        end
        default: refr[lane] = BYTE_W'($urandom_range(255));
      endcase
    end
  endtask

  // well-formed block, sometimes ending without a row marker
  task automatic send_block(input int rows, input int width);
    lane_bytes_t cur;
    lane_bytes_t refr;
    logic        rl;
    logic        bl;
    for (int r = 0; r < rows; r++)
      for (int w = 0; w < width; w++) begin
        make_lanes(cur, refr);
        rl = (w == width - 1);
        bl = rl && (r == rows - 1);
        if (bl && $urandom_range(3) == 0)
          rl = 1'b0;
        send_item(cur, refr, rl, bl);
      end
  endtask

  // mostly small blocks, a few large ones, some loose markers
  task automatic random_traffic(input int n_items);
    lane_bytes_t cur;
    lane_bytes_t refr;
    int          sent;
    int          rows;
    int          width;
    int          burst;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        burst = $urandom_range(1, 6);
        repeat (burst) begin
          make_lanes(cur, refr);
          send_item(cur, refr, 1'($urandom_range(1)), $urandom_range(7) == 0);
        end
        sent += burst;
      end else begin
        rows = ($urandom_range(29) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 4);
        width = ($urandom_range(29) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
        send_block(rows, width);
        sent += rows * width;
      end
      if ($urandom_range(19) == 0)
        drain_results();
    end
  endtask

  // stimulus and verdict
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // limit at its reset value: two full-swing rows, no exit
    send_item({LANES{8'hFF}}, '0, 1'b1, 1'b0);
    send_item('0, {LANES{8'hFF}}, 1'b1, 1'b1);
    // block end without row end, zero and mixed-sign lanes
    send_item({8'h12, 8'h34, 8'h56, 8'h78}, {8'h12, 8'h34, 8'h56, 8'h78}, 1'b0, 1'b1);
    send_item({8'h01, 8'hF0, 8'h80, 8'h7F}, {8'hFE, 8'h0F, 8'h7F, 8'h80}, 1'b0, 1'b1);

    // zero limit: exit on first row, rest of the block dropped
    write_limit('0);
    send_item({8'h00, 8'h00, 8'h00, 8'h01}, '0, 1'b1, 1'b0);
    send_item({LANES{8'hFF}}, '0, 1'b0, 1'b0);
    send_item({LANES{8'hFF}}, '0, 1'b1, 1'b0);
    send_item({LANES{8'hFF}}, '0, 1'b0, 1'b1);
    // a sum equal to the limit does not exit
    send_item({LANES{8'hA5}}, {LANES{8'hA5}}, 1'b1, 1'b0);
    send_item({LANES{8'h5A}}, {LANES{8'h5A}}, 1'b0, 1'b1);
    // exit on the last transaction, next block starts fresh
    send_item({8'h00, 8'h00, 8'h00, 8'h05}, '0, 1'b0, 1'b1);
    send_item('0, {8'h00, 8'h03, 8'h00, 8'h00}, 1'b0, 1'b1);

    // mid-range limit: equal, then above only at a row end
    write_limit(24'd1000);
    send_item({LANES{8'd250}}, '0, 1'b1, 1'b0);
    send_item({8'h00, 8'h00, 8'h00, 8'h01}, '0, 1'b0, 1'b0);
    send_item('0, '0, 1'b1, 1'b0);
    send_item({LANES{8'hFF}}, '0, 1'b1, 1'b1);
    send_item({LANES{8'hFF}}, '0, 1'b1, 1'b1);

    // three idling patterns, each through several limit settings
    for (int phase = 0; phase < 3; phase++) begin
      drain_results();
      case (phase)
        0: begin send_idle_pct = 16; stall_pct <= 86; end
        1: begin send_idle_pct = 86; stall_pct <= 16; end
        default: begin send_idle_pct = 0; stall_pct <= 0; end
      endcase
      write_limit(LIMIT_RESET);
      random_traffic(SEGMENT_ITEMS);
      write_limit('0);
      random_traffic(SEGMENT_ITEMS);
      write_limit(LIMIT_W'($urandom_range(300, 2500)));
      random_traffic(SEGMENT_ITEMS);
      write_limit(LIMIT_W'($urandom_range(0, 24'hFFFFFF)));
      random_traffic(SEGMENT_ITEMS);
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_results != 0)
      $display("%0d expected results never arrived", pending_results);
    $display("run covered %0d input transactions, %0d results (%0d early exits)",
             items_seen, results_seen, exits_seen);
    $display("%0d limit writes from zero to all ones, three idling patterns",
             limit_writes);
    if (fail_count == 0 && pending_results == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/sadee_pkg.sv
hw/rtl/sadee_diff.sv
hw/rtl/sadee_accum.sv
hw/rtl/block_sad_early_exit.sv
tb/sv/sad_checker.sv
tb/sv/testbench.sv
